[design/ec_hts_pkg.sv]
// ec_hts_pkg: types, codes and result builders for the EC host transaction sequencer.
// Depends on nothing; every other file of the block imports it.
package ec_hts_pkg;

    // Field widths
    localparam int KIND_W  = 3;
    localparam int ADDR_W  = 16;
    localparam int WIDTH_W = 7;
    localparam int DATA_W  = 64;
    localparam int BYTE_W  = 8;
    localparam int PORT_W  = 16;
    localparam int OP_W    = 2;
    localparam int RC_W    = 2;

    // Up to three results per input transaction
    localparam int RES_MAX = 3;
    localparam int CNT_W   = 2;

    // Input kinds
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STATUS = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DATA   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_GPE    = 3'd4;

    // Bus operations
    localparam logic [OP_W-1:0] BUS_NONE  = 2'd0;
    localparam logic [OP_W-1:0] BUS_WRITE = 2'd1;
    localparam logic [OP_W-1:0] BUS_READ  = 2'd2;

    // Result codes
    localparam logic [RC_W-1:0] RC_OK        = 2'd0;
    localparam logic [RC_W-1:0] RC_BAD_PARAM = 2'd1;
    localparam logic [RC_W-1:0] RC_NOT_FOUND = 2'd2;

    // EC commands and limits
    localparam logic [BYTE_W-1:0] CMD_READ  = 8'h80;
    localparam logic [BYTE_W-1:0] CMD_WRITE = 8'h81;
    localparam logic [BYTE_W-1:0] CMD_QUERY = 8'h84;
    localparam logic [ADDR_W-1:0] ADDR_MAX  = 16'h00FF;
    localparam logic [3:0]        MAX_BYTES = 4'd8;

    // EC status register bits
    localparam int ST_OBF_BIT = 0;
    localparam int ST_IBF_BIT = 1;
    localparam int ST_SCI_BIT = 5;

    // Configuration register indexes
    localparam logic CFG_DATA_PORT    = 1'b0;
    localparam logic CFG_COMMAND_PORT = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_CMD_IBF  = 3'd1,
        PH_WR_IBF   = 3'd2,
        PH_RD_OBF   = 3'd3,
        PH_RD_DATA  = 3'd4,
        PH_GPE_STAT = 3'd5,
        PH_GPE_OBF  = 3'd6,
        PH_GPE_DATA = 3'd7
    } t_phase;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ADDR_W-1:0]  address;
        logic [WIDTH_W-1:0] width_bits;
        logic [DATA_W-1:0]  write_value;
        logic [BYTE_W-1:0]  port_byte;
    } t_item;

    typedef struct packed {
        logic [OP_W-1:0]   bus_op;
        logic [PORT_W-1:0] port_address;
        logic [BYTE_W-1:0] write_byte;
        logic              done_res;
        logic [RC_W-1:0]   result_code;
        logic [DATA_W-1:0] read_value;
        logic              query_valid;
        logic [BYTE_W-1:0] query_code;
        logic              last;
    } t_result;

    typedef struct packed {
        t_phase            phase;
        logic              is_write_op;
        logic [7:0]        current_address;
        logic [3:0]        bytes_remaining;
        logic [2:0]        byte_position;
        logic [DATA_W-1:0] pending_write_data;
        logic [DATA_W-1:0] read_accumulator;
    } t_state;

    // Load request from the step logic into the result buffer
    typedef struct packed {
        logic             load;
        logic [CNT_W-1:0] count;
    } t_load;

    function automatic t_result f_port_write(input logic [PORT_W-1:0] port,
                                             input logic [BYTE_W-1:0] b);
        t_result r;
        r              = '0;
        r.bus_op       = BUS_WRITE;
        r.port_address = port;
        r.write_byte   = b;
        return r;
    endfunction

    function automatic t_result f_port_read(input logic [PORT_W-1:0] port);
        t_result r;
        r              = '0;
        r.bus_op       = BUS_READ;
        r.port_address = port;
        return r;
    endfunction

    function automatic t_result f_finish(input logic [RC_W-1:0]   rc,
                                         input logic [DATA_W-1:0] rv,
                                         input logic              qv,
                                         input logic [BYTE_W-1:0] qc);
        t_result r;
        r             = '0;
        r.done_res    = 1'b1;
        r.result_code = rc;
        r.read_value  = rv;
        r.query_valid = qv;
        r.query_code  = qc;
        return r;
    endfunction

endpackage

[design/ec_hts_req_if.sv]
// ec_hts_req_if: valid/ready channel carrying one request or port-response transaction.
// Depends on ec_hts_pkg for field widths.
interface ec_hts_req_if;
    import ec_hts_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [ADDR_W-1:0]   address;
    logic [WIDTH_W-1:0]  width_bits;
    logic [DATA_W-1:0]   write_value;
    logic [BYTE_W-1:0]   port_byte;

    modport source (output valid, kind, address, width_bits, write_value, port_byte,
                    input ready);
    modport sink   (input valid, kind, address, width_bits, write_value, port_byte,
                    output ready);
endinterface

[design/ec_hts_rsp_if.sv]
// ec_hts_rsp_if: valid/ready channel carrying one result transaction.
// Depends on ec_hts_pkg for field widths.
interface ec_hts_rsp_if;
    import ec_hts_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     bus_op;
    logic [PORT_W-1:0]   port_address;
    logic [BYTE_W-1:0]   write_byte;
    logic                done_res;
    logic [RC_W-1:0]     result_code;
    logic [DATA_W-1:0]   read_value;
    logic                query_valid;
    logic [BYTE_W-1:0]   query_code;
    logic                last;

    modport source (output valid, bus_op, port_address, write_byte, done_res, result_code,
                    read_value, query_valid, query_code, last,
                    input ready);
    modport sink   (input valid, bus_op, port_address, write_byte, done_res, result_code,
                    read_value, query_valid, query_code, last,
                    output ready);
endinterface

[design/ec_hts_step.sv]
// ec_hts_step: one step of the EC host protocol sequencer, purely combinational.
// Depends on ec_hts_pkg; maps current state and one input transaction to results.
module ec_hts_step (
    input  ec_hts_pkg::t_state                        i_state,
    input  ec_hts_pkg::t_item                         i_item,
    input  logic [ec_hts_pkg::PORT_W-1:0]             i_data_port,
    input  logic [ec_hts_pkg::PORT_W-1:0]             i_command_port,
    output ec_hts_pkg::t_state                        o_state,
    output ec_hts_pkg::t_result [ec_hts_pkg::RES_MAX-1:0] o_res,
    output logic [ec_hts_pkg::CNT_W-1:0]              o_count
);
    import ec_hts_pkg::*;

    logic [3:0]        bytes_raw;
    logic [3:0]        bytes_req;
    logic [3:0]        adv_rem;
    logic              adv_done;
    logic [BYTE_W-1:0] start_cmd;
    logic [BYTE_W-1:0] wr_byte;
    logic [DATA_W-1:0] acc_new;
    logic              st_obf;
    logic              st_ibf;
    logic              st_sci;
    t_state            nxt;
    t_result [RES_MAX-1:0] res;
    logic [CNT_W-1:0]  cnt;

    // Decoded helpers
    always_comb begin
        bytes_raw = i_item.width_bits[WIDTH_W-1:3];
        bytes_req = (bytes_raw > MAX_BYTES) ? MAX_BYTES : bytes_raw;
        adv_rem   = (i_state.bytes_remaining != 4'd0) ? i_state.bytes_remaining - 4'd1 : 4'd0;
        adv_done  = (adv_rem == 4'd0);
        start_cmd = i_state.is_write_op ? CMD_WRITE : CMD_READ;
        wr_byte   = BYTE_W'(i_state.pending_write_data >> {i_state.byte_position, 3'b000});
        acc_new   = i_state.read_accumulator
                  | (DATA_W'(i_item.port_byte) << {i_state.byte_position, 3'b000});
        st_obf    = i_item.port_byte[ST_OBF_BIT];
        st_ibf    = i_item.port_byte[ST_IBF_BIT];
        st_sci    = i_item.port_byte[ST_SCI_BIT];
    end

    // Protocol step
    always_comb begin
        nxt = i_state;
        res = '0;
        cnt = '0;
        case (i_state.phase)
            PH_IDLE: begin
                if (i_item.kind == KIND_READ || i_item.kind == KIND_WRITE) begin
                    cnt = 2'd1;
                    if (i_item.address > ADDR_MAX) begin
                        res[0] = f_finish(RC_BAD_PARAM, '0, 1'b0, '0);
                    end else if (bytes_req == 4'd0) begin
                        res[0] = f_finish(RC_OK, '0, 1'b0, '0);
                    end else if (i_data_port == '0) begin
                        res[0] = f_finish(RC_NOT_FOUND, '0, 1'b0, '0);
                    end else begin
                        nxt.is_write_op        = (i_item.kind == KIND_WRITE);
                        nxt.current_address    = i_item.address[7:0];
                        nxt.bytes_remaining    = bytes_req;
                        nxt.byte_position      = '0;
                        nxt.pending_write_data = i_item.write_value;
                        nxt.read_accumulator   = '0;
                        nxt.phase              = PH_CMD_IBF;
                        res[0] = f_port_write(i_command_port,
                            (i_item.kind == KIND_WRITE) ? CMD_WRITE : CMD_READ);
                        res[1] = f_port_read(i_command_port);
                        cnt    = 2'd2;
                    end
                end else if (i_item.kind == KIND_GPE) begin
                    res[0]    = f_port_read(i_command_port);
                    cnt       = 2'd1;
                    nxt.phase = PH_GPE_STAT;
                end
            end
            PH_CMD_IBF: begin
                if (i_item.kind == KIND_STATUS) begin
                    if (st_ibf) begin
                        res[0] = f_port_read(i_command_port);
                        cnt    = 2'd1;
                    end else begin
                        res[0]    = f_port_write(i_data_port, i_state.current_address);
                        res[1]    = f_port_read(i_command_port);
                        cnt       = 2'd2;
                        nxt.phase = i_state.is_write_op ? PH_WR_IBF : PH_RD_OBF;
                    end
                end
            end
            PH_WR_IBF: begin
                if (i_item.kind == KIND_STATUS) begin
                    if (st_ibf) begin
                        res[0] = f_port_read(i_command_port);
                        cnt    = 2'd1;
                    end else begin
                        res[0] = f_port_write(i_data_port, wr_byte);
                        nxt.current_address = i_state.current_address + 8'd1;
                        nxt.byte_position   = i_state.byte_position + 3'd1;
                        nxt.bytes_remaining = adv_rem;
                        if (adv_done) begin
                            res[1] = f_finish(RC_OK,
                                i_state.is_write_op ? '0 : i_state.read_accumulator,
                                1'b0, '0);
                            cnt       = 2'd2;
                            nxt.phase = PH_IDLE;
                        end else begin
                            res[1]    = f_port_write(i_command_port, start_cmd);
                            res[2]    = f_port_read(i_command_port);
                            cnt       = 2'd3;
                            nxt.phase = PH_CMD_IBF;
                        end
                    end
                end
            end
            PH_RD_OBF: begin
                if (i_item.kind == KIND_STATUS) begin
                    res[0] = f_port_read(st_obf ? i_data_port : i_command_port);
                    cnt    = 2'd1;
                    if (st_obf) begin
                        nxt.phase = PH_RD_DATA;
                    end
                end
            end
            PH_RD_DATA: begin
                if (i_item.kind == KIND_DATA) begin
                    nxt.read_accumulator = acc_new;
                    nxt.current_address  = i_state.current_address + 8'd1;
                    nxt.byte_position    = i_state.byte_position + 3'd1;
                    nxt.bytes_remaining  = adv_rem;
                    if (adv_done) begin
                        res[0] = f_finish(RC_OK, i_state.is_write_op ? '0 : acc_new,
                                          1'b0, '0);
                        cnt       = 2'd1;
                        nxt.phase = PH_IDLE;
                    end else begin
                        res[0]    = f_port_write(i_command_port, start_cmd);
                        res[1]    = f_port_read(i_command_port);
                        cnt       = 2'd2;
                        nxt.phase = PH_CMD_IBF;
                    end
                end
            end
            PH_GPE_STAT: begin
                if (i_item.kind == KIND_STATUS) begin
                    if (st_sci) begin
                        res[0]    = f_port_write(i_command_port, CMD_QUERY);
                        res[1]    = f_port_read(i_command_port);
                        cnt       = 2'd2;
                        nxt.phase = PH_GPE_OBF;
                    end else begin
                        res[0]    = f_finish(RC_OK, '0, 1'b0, '0);
                        cnt       = 2'd1;
                        nxt.phase = PH_IDLE;
                    end
                end
            end
            PH_GPE_OBF: begin
                if (i_item.kind == KIND_STATUS) begin
                    res[0] = f_port_read(st_obf ? i_data_port : i_command_port);
                    cnt    = 2'd1;
                    if (st_obf) begin
                        nxt.phase = PH_GPE_DATA;
                    end
                end
            end
            PH_GPE_DATA: begin
                if (i_item.kind == KIND_DATA) begin
                    res[0]    = f_finish(RC_OK, '0, 1'b1, i_item.port_byte);
                    cnt       = 2'd1;
                    nxt.phase = PH_IDLE;
                end
            end
            default: begin
                nxt.phase = PH_IDLE;
            end
        endcase

        // Mark the final result of this transaction
        for (int i = 0; i < RES_MAX; i++) begin
            res[i].last = (CNT_W'(i + 1) == cnt);
        end
    end

    assign o_state = nxt;
    assign o_res   = res;
    assign o_count = cnt;

endmodule

[design/ec_hts_rsp_buf.sv]
// ec_hts_rsp_buf: result register bank that holds up to three results and drains them in order.
// Depends on ec_hts_pkg and ec_hts_rsp_if.
module ec_hts_rsp_buf (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  ec_hts_pkg::t_load                            i_load,
    input  ec_hts_pkg::t_result [ec_hts_pkg::RES_MAX-1:0] i_res,
    output logic                                         o_free,
    ec_hts_rsp_if.source                                 o_rsp
);
    import ec_hts_pkg::*;

    logic [CNT_W-1:0]      r_left;
    logic [CNT_W-1:0]      n_left;
    logic [CNT_W-1:0]      r_idx;
    logic [CNT_W-1:0]      n_idx;
    t_result [RES_MAX-1:0] r_ent;
    t_result               cur;
    logic                  pop;

    // Handshake and free-slot status
    assign pop    = o_rsp.valid && o_rsp.ready;
    assign o_free = (r_left == '0) || (r_left == 2'd1 && pop);

    // Remaining count and read pointer
    always_comb begin
        n_left = r_left;
        n_idx  = r_idx;
        if (i_load.load) begin
            n_left = i_load.count;
            n_idx  = '0;
        end else if (pop) begin
            n_left = r_left - 2'd1;
            n_idx  = r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_idx  <= '0;
        end else begin
            r_left <= n_left;
            r_idx  <= n_idx;
        end
    end

    // Result payload registers
    always_ff @(posedge i_clk) begin
        if (i_load.load) begin
            r_ent <= i_res;
        end
    end

    // Drive the output channel from the current entry
    always_comb begin
        cur = r_ent[0];
        case (r_idx)
            2'd0:    cur = r_ent[0];
            2'd1:    cur = r_ent[1];
            2'd2:    cur = r_ent[2];
            default: cur = r_ent[0];
        endcase
    end

    assign o_rsp.valid        = (r_left != '0);
    assign o_rsp.bus_op       = cur.bus_op;
    assign o_rsp.port_address = cur.port_address;
    assign o_rsp.write_byte   = cur.write_byte;
    assign o_rsp.done_res     = cur.done_res;
    assign o_rsp.result_code  = cur.result_code;
    assign o_rsp.read_value   = cur.read_value;
    assign o_rsp.query_valid  = cur.query_valid;
    assign o_rsp.query_code   = cur.query_code;
    assign o_rsp.last         = cur.last;

endmodule

[design/ec_host_transaction_sequencer_unit.sv]
// ec_host_transaction_sequencer_unit: top level of the EC host transaction sequencer.
// Depends on ec_hts_pkg, ec_hts_req_if, ec_hts_rsp_if, ec_hts_step and ec_hts_rsp_buf.
//
//  channel   direction  carries
//  i_req     in         requests, GPE events, returned status and data bytes
//  o_rsp     out        port operations and done results, 0 to 3 per input transaction
//  i_cfg_*   in         write-only data_port / command_port registers
//
// An input transaction is registered, stepped through the protocol state machine and its
// results loaded into the result registers once they are free; one result leaves per
// cycle while o_rsp.ready is high. Sustained rate: one input per cycle while each yields
// at most one result and o_rsp does not stall; an input that yields more results holds
// the next one until its last result leaves, set by the single output channel.
// Reset is synchronous and active low; it clears state, configuration and both valid flags.
// Output stalls back up through the result registers into the input register and i_req.ready.
module ec_host_transaction_sequencer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [ec_hts_pkg::PORT_W-1:0] i_cfg_wdata,
    ec_hts_req_if.sink                    i_req,
    ec_hts_rsp_if.source                  o_rsp
);
    import ec_hts_pkg::*;

    logic [PORT_W-1:0]     r_data_port;
    logic [PORT_W-1:0]     r_command_port;
    logic                  r_in_valid;
    t_item                 r_item;
    t_state                r_state;
    t_state                n_state;
    t_result [RES_MAX-1:0] step_res;
    logic [CNT_W-1:0]      step_cnt;
    logic                  buf_free;
    logic                  consume;
    t_load                 load;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_port    <= '0;
            r_command_port <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DATA_PORT:    r_data_port    <= i_cfg_wdata;
                CFG_COMMAND_PORT: r_command_port <= i_cfg_wdata;
                default:          r_data_port    <= r_data_port;
            endcase
        end
    end

    // Input register: refills in the cycle it is consumed
    assign consume     = r_in_valid && buf_free;
    assign i_req.ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_item.kind        <= i_req.kind;
            r_item.address     <= i_req.address;
            r_item.width_bits  <= i_req.width_bits;
            r_item.write_value <= i_req.write_value;
            r_item.port_byte   <= i_req.port_byte;
        end
    end

    // Protocol state advances once per consumed transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, default: '0};
        end else if (consume) begin
            r_state <= n_state;
        end
    end

    ec_hts_step u_step (
        .i_state        (r_state),
        .i_item         (r_item),
        .i_data_port    (r_data_port),
        .i_command_port (r_command_port),
        .o_state        (n_state),
        .o_res          (step_res),
        .o_count        (step_cnt)
    );

    assign load.load  = consume;
    assign load.count = step_cnt;

    ec_hts_rsp_buf u_rsp_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_res   (step_res),
        .o_free  (buf_free),
        .o_rsp   (o_rsp)
    );

`ifndef SYNTHESIS
    // Results of one transaction leave back to back until the one marked last
    a_burst_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.ready && !o_rsp.last |=> o_rsp.valid)
        else $error("result burst broken before last");

    // A query byte only appears on the closing result
    a_query_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.query_valid |-> o_rsp.done_res && o_rsp.last)
        else $error("query byte outside a done result");

    // A result without a bus operation is always a done result
    a_none_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.bus_op == BUS_NONE |-> o_rsp.done_res)
        else $error("empty result not marked done");

    // The protocol is back in idle after a transaction whose first result is done is loaded
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        consume && step_cnt != '0 && step_res[0].done_res |=> r_state.phase == PH_IDLE)
        else $error("done result left the sequencer busy");
`endif

endmodule

[test/testbench.sv]
// testbench: self-checking bench for ec_host_transaction_sequencer_unit.
// Depends on ec_hts_pkg, ec_hts_req_if, ec_hts_rsp_if and the RTL; drives a directed table,
// then random request/response sequences under several port settings.
module testbench;
    import ec_hts_pkg::*;

    localparam int WATCHDOG_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RANDOM_ITEMS    = 70;
    localparam int CFG_PHASES      = 5;

    localparam logic [PORT_W-1:0] DIR_DATA_PORT    = 16'h0062;
    localparam logic [PORT_W-1:0] DIR_COMMAND_PORT = 16'h0066;

    // Kinds the block must ignore
    localparam logic [KIND_W-1:0] KIND_RSVD_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_RSVD_HI = 3'd7;

    localparam t_result NO_RESULT = '0;

    typedef struct {
        logic    reconfig;
        t_item   item;
        logic    typed;
        t_result want;
    } t_dir_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [PORT_W-1:0]   i_cfg_wdata;

    ec_hts_req_if req_ch();
    ec_hts_rsp_if rsp_ch();

    ec_host_transaction_sequencer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    always #5 i_clk = ~i_clk;

    // Predicted sequencer state and port settings
    t_phase            ec_phase = PH_IDLE;
    logic              ec_is_wr = 1'b0;
    logic [7:0]        ec_addr  = '0;
    logic [3:0]        ec_left  = '0;
    logic [2:0]        ec_pos   = '0;
    logic [DATA_W-1:0] ec_wdata = '0;
    logic [DATA_W-1:0] ec_racc  = '0;
    logic [PORT_W-1:0] cfg_data_port    = '0;
    logic [PORT_W-1:0] cfg_command_port = '0;

    t_result  step_ops[$];      // port operations caused by the latest transaction
    t_result  awaited_ops[$];   // port operations not yet seen on o_rsp
    t_dir_row directed_rows[$];

    int mismatches    = 0;
    int items_sent    = 0;
    int req_count     = 0;
    int req_idle_max  = 0;
    int rsp_count     = 0;
    int rsp_idle_max  = 0;
    int rsp_stall     = 0;
    int quiet_cycles  = 0;

    function automatic t_result pack_result(input logic [OP_W-1:0] op,
                                            input logic [PORT_W-1:0] port,
                                            input logic [BYTE_W-1:0] wb,
                                            input logic done,
                                            input logic [RC_W-1:0] rc,
                                            input logic [DATA_W-1:0] rv,
                                            input logic qv,
                                            input logic [BYTE_W-1:0] qc,
                                            input logic fin);
        t_result r;
        r.bus_op       = op;
        r.port_address = port;
        r.write_byte   = wb;
        r.done_res     = done;
        r.result_code  = rc;
        r.read_value   = rv;
        r.query_valid  = qv;
        r.query_code   = qc;
        r.last         = fin;
        return r;
    endfunction

    function automatic t_result lone_done(input logic [RC_W-1:0] rc);
        return pack_result(BUS_NONE, '0, '0, 1'b1, rc, '0, 1'b0, '0, 1'b1);
    endfunction

    function automatic t_item pack_item(input logic [KIND_W-1:0] kind,
                                        input logic [ADDR_W-1:0] addr,
                                        input logic [WIDTH_W-1:0] width,
                                        input logic [DATA_W-1:0] wval,
                                        input logic [BYTE_W-1:0] pb);
        t_item it;
        it.kind        = kind;
        it.address     = addr;
        it.width_bits  = width;
        it.write_value = wval;
        it.port_byte   = pb;
        return it;
    endfunction

    function automatic void add_row(input logic reconfig, input t_item it,
                                    input logic typed, input t_result want);
        t_dir_row row;
        row.reconfig = reconfig;
        row.item     = it;
        row.typed    = typed;
        row.want     = want;
        directed_rows.push_back(row);
    endfunction

    // Predictor: port operation helpers
    function automatic void emit_op(input logic [OP_W-1:0] op, input logic [PORT_W-1:0] port,
                                    input logic [BYTE_W-1:0] wb);
        step_ops.push_back(pack_result(op, port, wb, 1'b0, RC_OK, '0, 1'b0, '0, 1'b0));
    endfunction

    function automatic void finish_op(input logic [RC_W-1:0] rc, input logic [DATA_W-1:0] rv,
                                      input logic qv, input logic [BYTE_W-1:0] qc);
        step_ops.push_back(pack_result(BUS_NONE, '0, '0, 1'b1, rc, rv, qv, qc, 1'b0));
        ec_phase = PH_IDLE;
    endfunction

    // Each byte opens with the read or write command and a status poll
    function automatic void start_byte();
        emit_op(BUS_WRITE, cfg_command_port, ec_is_wr ? CMD_WRITE : CMD_READ);
        emit_op(BUS_READ, cfg_command_port, '0);
        ec_phase = PH_CMD_IBF;
    endfunction

    // Advance to the next EC address; the address wraps within 8 bits
    function automatic void next_byte();
        ec_addr = ec_addr + 8'd1;
        ec_pos  = ec_pos + 3'd1;
        if (ec_left != 0) ec_left = ec_left - 4'd1;
        if (ec_left == 0) begin
            finish_op(RC_OK, ec_is_wr ? 64'd0 : ec_racc, 1'b0, '0);
        end else begin
            start_byte();
        end
    endfunction

    // Predictor: one accepted transaction in, its port operations into step_ops
    function automatic void sequence_item(input t_item it);
        logic [3:0] nbytes;
        t_result    fin_op;
        step_ops.delete();
        nbytes = (it.width_bits >= 7'd64) ? MAX_BYTES : 4'(it.width_bits >> 3);
        case (ec_phase)
            PH_IDLE: begin
                if (it.kind == KIND_READ || it.kind == KIND_WRITE) begin
                    if (it.address > ADDR_MAX) begin
                        finish_op(RC_BAD_PARAM, '0, 1'b0, '0);
                    end else if (nbytes == 0) begin
                        finish_op(RC_OK, '0, 1'b0, '0);
                    end else if (cfg_data_port == 0) begin
                        finish_op(RC_NOT_FOUND, '0, 1'b0, '0);
                    end else begin
                        ec_is_wr = (it.kind == KIND_WRITE);
                        ec_addr  = it.address[7:0];
                        ec_left  = nbytes;
                        ec_pos   = '0;
                        ec_wdata = it.write_value;
                        ec_racc  = '0;
                        start_byte();
                    end
                end else if (it.kind == KIND_GPE) begin
                    emit_op(BUS_READ, cfg_command_port, '0);
                    ec_phase = PH_GPE_STAT;
                end
            end
            PH_CMD_IBF: if (it.kind == KIND_STATUS) begin
                if (it.port_byte[ST_IBF_BIT]) begin
                    emit_op(BUS_READ, cfg_command_port, '0);
                end else begin
                    emit_op(BUS_WRITE, cfg_data_port, ec_addr);
                    emit_op(BUS_READ, cfg_command_port, '0);
                    ec_phase = ec_is_wr ? PH_WR_IBF : PH_RD_OBF;
                end
            end
            PH_WR_IBF: if (it.kind == KIND_STATUS) begin
                if (it.port_byte[ST_IBF_BIT]) begin
                    emit_op(BUS_READ, cfg_command_port, '0);
                end else begin
                    emit_op(BUS_WRITE, cfg_data_port, ec_wdata[{ec_pos, 3'b000} +: 8]);
                    next_byte();
                end
            end
            PH_RD_OBF, PH_GPE_OBF: if (it.kind == KIND_STATUS) begin
                if (it.port_byte[ST_OBF_BIT]) begin
                    emit_op(BUS_READ, cfg_data_port, '0);
                    ec_phase = (ec_phase == PH_RD_OBF) ? PH_RD_DATA : PH_GPE_DATA;
                end else begin
                    emit_op(BUS_READ, cfg_command_port, '0);
                end
            end
            PH_RD_DATA: if (it.kind == KIND_DATA) begin
                ec_racc[{ec_pos, 3'b000} +: 8] = it.port_byte;
                next_byte();
            end
            PH_GPE_STAT: if (it.kind == KIND_STATUS) begin
                if (it.port_byte[ST_SCI_BIT]) begin
                    emit_op(BUS_WRITE, cfg_command_port, CMD_QUERY);
                    emit_op(BUS_READ, cfg_command_port, '0);
                    ec_phase = PH_GPE_OBF;
                end else begin
                    finish_op(RC_OK, '0, 1'b0, '0);
                end
            end
            PH_GPE_DATA: if (it.kind == KIND_DATA) begin
                finish_op(RC_OK, '0, 1'b1, it.port_byte);
            end
            default: ec_phase = PH_IDLE;
        endcase
        if (step_ops.size() > 0) begin
            fin_op      = step_ops.pop_back();
            fin_op.last = 1'b1;
            step_ops.push_back(fin_op);
        end
    endfunction

    function automatic t_item random_item();
        t_item it;
        it.kind        = 3'($urandom_range(0, 7));
        it.address     = 16'($urandom);
        it.width_bits  = 7'($urandom);
        it.write_value = {$urandom, $urandom};
        it.port_byte   = 8'($urandom);
        return it;
    endfunction

    // Well-formed reply to what the sequencer is waiting for; most polls succeed
    function automatic t_item response_item();
        t_item it;
        logic  hit;
        it      = random_item();
        hit     = ($urandom_range(0, 2) != 0);
        it.kind = KIND_STATUS;
        case (ec_phase)
            PH_CMD_IBF, PH_WR_IBF: it.port_byte[ST_IBF_BIT] = ~hit;
            PH_RD_OBF, PH_GPE_OBF: it.port_byte[ST_OBF_BIT] = hit;
            PH_GPE_STAT:           it.port_byte[ST_SCI_BIT] = hit;
            default:               it.kind = KIND_DATA;
        endcase
        return it;
    endfunction

    // Mid-sequence junk: requests, GPE, reserved kinds or the wrong reply kind
    function automatic t_item noise_item();
        t_item it;
        it = random_item();
        if (it.kind == KIND_STATUS || it.kind == KIND_DATA) begin
            it.kind = (ec_phase == PH_RD_DATA || ec_phase == PH_GPE_DATA) ? KIND_STATUS
                                                                          : KIND_DATA;
        end
        return it;
    endfunction

    // Offer one transaction on i_req and wait until it is taken
    task automatic send_item(input t_item it);
        int gap;
        req_count++;
        if (req_count % 16 == 0) req_idle_max = $urandom_range(0, 3);
        gap = $urandom_range(0, req_idle_max);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.kind        <= it.kind;
        req_ch.address     <= it.address;
        req_ch.width_bits  <= it.width_bits;
        req_ch.write_value <= it.write_value;
        req_ch.port_byte   <= it.port_byte;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic apply_item(input t_item it, input logic typed, input t_result want);
        send_item(it);
        sequence_item(it);
        if (typed) begin
            awaited_ops.push_back(want);
        end else begin
            foreach (step_ops[i]) awaited_ops.push_back(step_ops[i]);
        end
    endtask

    // Let the block go idle; ignored transactions may still be in flight
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (awaited_ops.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_ports(input logic [PORT_W-1:0] dport, input logic [PORT_W-1:0] cport);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DATA_PORT;
        i_cfg_wdata <= dport;
        @(posedge i_clk);
        i_cfg_index <= CFG_COMMAND_PORT;
        i_cfg_wdata <= cport;
        @(posedge i_clk);
        i_cfg_we         <= 1'b0;
        cfg_data_port    = dport;
        cfg_command_port = cport;
    endtask

    // One request or GPE with its full reply sequence, or a lone ignored transaction
    task automatic run_transaction();
        t_item it;
        int    pick;
        it   = random_item();
        pick = $urandom_range(0, 19);
        if (pick < 8) begin
            it.kind = KIND_READ;
        end else if (pick < 15) begin
            it.kind = KIND_WRITE;
        end else if (pick < 18) begin
            it.kind = KIND_GPE;
        end else if (it.kind <= KIND_WRITE || it.kind == KIND_GPE) begin
            it.kind = 3'($urandom_range(KIND_RSVD_LO, KIND_RSVD_HI));
        end
        // Mostly short accesses; a few wide, saturated or empty ones
        if (pick < 15) begin
            case ($urandom_range(0, 9))
                0:       it.width_bits = 7'($urandom_range(0, 7));
                1:       it.width_bits = 7'($urandom_range(65, 127));
                2:       it.width_bits = 7'd64;
                default: it.width_bits = 7'($urandom_range(8, 31));
            endcase
            case ($urandom_range(0, 9))
                0:       ;
                1:       it.address = 16'($urandom_range(248, 255));
                default: it.address = 16'($urandom_range(0, 255));
            endcase
        end
        apply_item(it, 1'b0, NO_RESULT);
        if (pick < 18) items_sent++;
        while (ec_phase != PH_IDLE) begin
            if ($urandom_range(0, 7) == 0) apply_item(noise_item(), 1'b0, NO_RESULT);
            apply_item(response_item(), 1'b0, NO_RESULT);
            items_sent++;
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %h got %h", $time, name, want, got);
        end
    endtask

    // Result side: check each transaction, then draw the next stall
    always @(posedge i_clk) begin : rsp_side
        t_result got;
        t_result want;
        if (rsp_ch.valid && rsp_ch.ready) begin
            got = pack_result(rsp_ch.bus_op, rsp_ch.port_address, rsp_ch.write_byte,
                              rsp_ch.done_res, rsp_ch.result_code, rsp_ch.read_value,
                              rsp_ch.query_valid, rsp_ch.query_code, rsp_ch.last);
            if (awaited_ops.size() == 0) begin
                mismatches++;
                $display("%0t: result expected none got op %0d port %h byte %h done %b",
                         $time, got.bus_op, got.port_address, got.write_byte, got.done_res);
            end else begin
                want = awaited_ops.pop_front();
                compare_field("bus_op", 64'(want.bus_op), 64'(got.bus_op));
                compare_field("port_address", 64'(want.port_address),
                              64'(got.port_address));
                compare_field("write_byte", 64'(want.write_byte), 64'(got.write_byte));
                compare_field("done_res", 64'(want.done_res), 64'(got.done_res));
                compare_field("result_code", 64'(want.result_code), 64'(got.result_code));
                compare_field("read_value", want.read_value, got.read_value);
                compare_field("query_valid", 64'(want.query_valid), 64'(got.query_valid));
                compare_field("query_code", 64'(want.query_code), 64'(got.query_code));
                compare_field("last", 64'(want.last), 64'(got.last));
            end
            rsp_count++;
            if (rsp_count % 16 == 0) rsp_idle_max = $urandom_range(0, 3);
            rsp_stall = $urandom_range(0, rsp_idle_max);
        end else if (rsp_stall > 0) begin
            rsp_stall--;
        end
        rsp_ch.ready <= (rsp_stall == 0);
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = CFG_DATA_PORT;
        i_cfg_wdata        = '0;
        req_ch.valid       = 1'b0;
        req_ch.kind        = KIND_READ;
        req_ch.address     = '0;
        req_ch.width_bits  = '0;
        req_ch.write_value = '0;
        req_ch.port_byte   = '0;
        rsp_ch.ready       = 1'b0;

        // Ports at reset: parameter errors, empty access, absent controller, ignored kinds, GPE
        add_row(1'b0, pack_item(KIND_READ, 16'h0100, 7'd8, '0, '0), 1'b1,
                lone_done(RC_BAD_PARAM));
        add_row(1'b0, pack_item(KIND_WRITE, 16'hFFFF, 7'd64, '1, '1), 1'b1,
                lone_done(RC_BAD_PARAM));
        add_row(1'b0, pack_item(KIND_READ, 16'h0000, 7'd0, '0, '0), 1'b1, lone_done(RC_OK));
        add_row(1'b0, pack_item(KIND_WRITE, 16'h00FF, 7'd7, '1, '0), 1'b1, lone_done(RC_OK));
        add_row(1'b0, pack_item(KIND_READ, 16'h0000, 7'd8, '0, '0), 1'b1,
                lone_done(RC_NOT_FOUND));
        add_row(1'b0, pack_item(KIND_RSVD_LO, '0, 7'd8, '0, '0), 1'b0, NO_RESULT);
        add_row(1'b0, pack_item(KIND_RSVD_HI, '0, 7'd8, '0, '0), 1'b0, NO_RESULT);
        add_row(1'b0, pack_item(KIND_STATUS, '0, '0, '0, 8'hFF), 1'b0, NO_RESULT);
        add_row(1'b0, pack_item(KIND_GPE, '0, '0, '0, '0), 1'b1,
                pack_result(BUS_READ, '0, '0, 1'b0, RC_OK, '0, 1'b0, '0, 1'b1));
        add_row(1'b0, pack_item(KIND_STATUS, '0, '0, '0, 8'h00), 1'b1, lone_done(RC_OK));
        // One-byte read at the top of EC space, with polls and ignored transactions
        add_row(1'b1, pack_item(KIND_READ, 16'h00FF, 7'd8, '0, '0), 1'b0, NO_RESULT);
        add_row(1'b0, pack_item(KIND_WRITE, 16'h0010, 7'd8, '1, '0), 1'b0, NO_RESULT);
        add_row(1'b0, pack_item(KIND_DATA, '0, '0, '0, 8'h55), 1'b0, NO_RESULT);
        add_row(1'b0, pack_item(KIND_STATUS, '0, '0, '0, 8'h02), 1'b0, NO_RESULT);
        add_row(1'b0, pack_item(KIND_STATUS, '0, '0, '0, 8'hFD), 1'b0, NO_RESULT);
        add_row(1'b0, pack_item(KIND_STATUS, '0, '0, '0, 8'hFE), 1'b0, NO_RESULT);
        add_row(1'b0, pack_item(KIND_STATUS, '0, '0, '0, 8'h01), 1'b0, NO_RESULT);
        add_row(1'b0, pack_item(KIND_DATA, '0, '0, '0, 8'hFF), 1'b0, NO_RESULT);
        // One-byte write
        add_row(1'b0, pack_item(KIND_WRITE, 16'h0080, 7'd15, 64'h0123_4567_89AB_CD5A, '0),
                1'b0, NO_RESULT);
        add_row(1'b0, pack_item(KIND_STATUS, '0, '0, '0, 8'h00), 1'b0, NO_RESULT);
        add_row(1'b0, pack_item(KIND_STATUS, '0, '0, '0, 8'h02), 1'b0, NO_RESULT);
        add_row(1'b0, pack_item(KIND_STATUS, '0, '0, '0, 8'h00), 1'b0, NO_RESULT);
        // GPE with SCI pending and a query byte
        add_row(1'b0, pack_item(KIND_GPE, '0, '0, '0, '0), 1'b0, NO_RESULT);
        add_row(1'b0, pack_item(KIND_STATUS, '0, '0, '0, 8'h20), 1'b0, NO_RESULT);
        add_row(1'b0, pack_item(KIND_STATUS, '0, '0, '0, 8'h00), 1'b0, NO_RESULT);
        add_row(1'b0, pack_item(KIND_STATUS, '0, '0, '0, 8'h01), 1'b0, NO_RESULT);
        add_row(1'b0, pack_item(KIND_DATA, '0, '0, '0, 8'h00), 1'b0, NO_RESULT);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].reconfig) begin
                drain();
                set_ports(DIR_DATA_PORT, DIR_COMMAND_PORT);
            end
            apply_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        end

        // Random sequences under extreme, absent and random port settings
        for (int ph = 0; ph < CFG_PHASES; ph++) begin
            drain();
            case (ph)
                0:       set_ports(16'hFFFF, 16'hFFFF);
                1:       set_ports(16'h0001, 16'h0000);
                2:       set_ports(16'h0000, 16'($urandom));
                default: set_ports(16'($urandom_range(1, 65535)), 16'($urandom));
            endcase
            while (items_sent < (ph + 1) * RANDOM_ITEMS / CFG_PHASES) run_transaction();
        end

        drain();
        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
